FILE: hw/rtl/okl_pkg.sv
// shared types, codes and sizes for the ordered keyed list table
// used by okl_ctrl, okl_dpath and ordered_keyed_list_table; no dependencies
package okl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int ENT_W    = KEY_W + VAL_W;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 88;

  // request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_POP    = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_FIND   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    A_ZERO,
    A_TAIL,
    A_IDX1,
    A_IDX2
  } rd_sel_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_ZERO,
    I_INC
  } idx_op_t;

  typedef struct packed {
    logic       load_req;
    logic       clear;
    logic       append;
    logic       rd_en;
    rd_sel_t    rd_sel;
    idx_op_t    idx_op;
    logic       wr_shift;
    logic       capture;
    logic       remove;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } okl_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       empty;
    logic       full;
    logic       match;
    logic       last;
    logic       last2;
  } okl_stat_t;

  function automatic logic [6:0] to_out7(input logic [CNT_W-1:0] c);
    logic [CNT_W+6:0] w;
    w = {7'd0, c};
    return w[6:0];
  endfunction

endpackage

FILE: hw/rtl/okl_ctrl.sv
// sequencer for the ordered keyed list table: request dispatch, scan and shift
// depends on okl_pkg; drives okl_dpath through okl_cmd_t
module okl_ctrl
  import okl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  okl_stat_t stat,
  output okl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_WAIT,
    S_SCAN,
    S_SHIFT,
    S_REMOVE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESULT;
        case (stat.req)
          REQ_CLEAR: cmd.clear = 1'b1;
          REQ_APPEND: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          REQ_POP: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_TAIL;
              state_nxt  = S_POP_WAIT;
            end
          end
          REQ_DELETE, REQ_FIND: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_ZERO;
              cmd.idx_op = I_ZERO;
              state_nxt  = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_POP_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_REMOVE;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.capture = 1'b1;
          if (stat.req == REQ_FIND) begin
            state_nxt = S_RESULT;
          end else if (stat.last) begin
            state_nxt = S_REMOVE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = A_IDX1;
            state_nxt  = S_SHIFT;
          end
        end else if (stat.last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = A_IDX1;
          cmd.idx_op = I_INC;
        end
      end
      S_SHIFT: begin
        cmd.wr_shift = 1'b1;
        if (stat.last2) begin
          state_nxt = S_REMOVE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = A_IDX2;
          cmd.idx_op = I_INC;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_req) begin
        in_tready_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
        in_tready_r  <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/okl_dpath.sv
// datapath for the ordered keyed list table: entry memory, counts, result register
// depends on okl_pkg; controlled by okl_ctrl through okl_cmd_t
module okl_dpath
  import okl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  okl_cmd_t         cmd,
  output okl_stat_t        stat,
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W:0]   X_ONE   = (CNT_W + 1)'(1);
  localparam logic [CNT_W:0]   X_TWO   = (CNT_W + 1)'(2);

  logic [ENT_W-1:0] mem [CAPACITY];

  logic [2:0]       req_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] idx_r;
  logic [ENT_W-1:0] rdata_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] even_r;
  logic [CNT_W-1:0] odd_r;
  logic [1:0]       res_status_r;
  logic [KEY_W-1:0] rk_r;
  logic [VAL_W-1:0] rv_r;
  logic [OUT_W-1:0] out_tdata_r;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             wr_en;
  logic [CNT_W:0]   idx_x;
  logic [CNT_W:0]   fill_x;

  // entry layout: key in the high half, value in the low half
  assign idx_x  = (CNT_W + 1)'(idx_r);
  assign fill_x = (CNT_W + 1)'(fill_r);

  assign stat.req   = req_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == CNT_W'(CAPACITY));
  assign stat.match = (rdata_r[ENT_W-1:VAL_W] == key_r);
  assign stat.last  = ((idx_x + X_ONE) >= fill_x);
  assign stat.last2 = ((idx_x + X_TWO) >= fill_x);

  always_comb begin
    case (cmd.rd_sel)
      A_ZERO:  rd_addr = '0;
      A_TAIL:  rd_addr = IDX_W'(fill_r - CNT_ONE);
      A_IDX1:  rd_addr = idx_r + IDX_ONE;
      A_IDX2:  rd_addr = idx_r + IDX_TWO;
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.append || cmd.wr_shift;
  assign wr_addr = cmd.append ? IDX_W'(fill_r) : idx_r;
  assign wr_data = cmd.append ? {key_r, val_r} : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_tdata[2:0];
      key_r <= in_tdata[34:3];
      val_r <= in_tdata[66:35];
    end
    case (cmd.idx_op)
      I_HOLD:  idx_r <= idx_r;
      I_ZERO:  idx_r <= '0;
      I_INC:   idx_r <= idx_r + IDX_ONE;
      default: idx_r <= idx_r;
    endcase
    if (cmd.load_req) begin
      res_status_r <= ST_OK;
      rk_r         <= '0;
      rv_r         <= '0;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.capture) begin
      rk_r <= rdata_r[ENT_W-1:VAL_W];
      rv_r <= rdata_r[VAL_W-1:0];
    end
    if (cmd.load_out) begin
      out_tdata_r <= {1'b0, to_out7(odd_r), to_out7(even_r), to_out7(fill_r),
                      rv_r, rk_r, res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      even_r <= '0;
      odd_r  <= '0;
    end else if (cmd.clear) begin
      fill_r <= '0;
      even_r <= '0;
      odd_r  <= '0;
    end else if (cmd.append) begin
      fill_r <= fill_r + CNT_ONE;
      if (val_r[0]) begin
        odd_r <= odd_r + CNT_ONE;
      end else begin
        even_r <= even_r + CNT_ONE;
      end
    end else if (cmd.remove) begin
      fill_r <= fill_r - CNT_ONE;
      if (rv_r[0]) begin
        odd_r <= odd_r - CNT_ONE;
      end else begin
        even_r <= even_r - CNT_ONE;
      end
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: hw/rtl/ordered_keyed_list_table.sv
// top level of the ordered keyed list table: sequencer plus datapath
// depends on okl_pkg, okl_ctrl and okl_dpath
//
//   channel   dir  fields (lowest bit first)
//   in_*      in   req_type[2:0], key[34:3], value[66:35], zero fill to 72
//   out_*     out  status, out_key, out_value, entry_count, even_count,
//                  odd_count, zero fill to 88
//
// one request at a time; the entry memory has one read and one write port,
// so scans and gap closing walk one entry per cycle
// find stops at the first match; delete scans to the match, then shifts every later entry up;
// find or delete with no match scans every entry
// a new request is taken while the previous result waits on out_tready
// reset (rst_n low, synchronous) empties the table; entry memory is not cleared
module ordered_keyed_list_table
  import okl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // req_type, key, value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, out_key, out_value, entry_count,
                                       // even_count, odd_count
);

  okl_cmd_t  cmd;
  okl_stat_t stat;

  okl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  okl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

FILE: bench/ordered_keyed_list_table_tb.sv
// self-checking bench for ordered_keyed_list_table: directed requests, then random ones
// across idle and back-pressure phases; checked against typed results or a behavioural model
// depends on okl_pkg and the ordered_keyed_list_table rtl
module ordered_keyed_list_table_tb;
  import okl_pkg::*;

  localparam int SEG_ITEMS      = 110;
  localparam int NUM_SEGS       = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 40;
  localparam int NUM_DIRECTED   = 23;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key;
    logic [31:0] value;
    logic [6:0]  count;
    logic [6:0]  even;
    logic [6:0]  odd;
  } result_t;

  typedef struct {
    req_t    rq;
    bit      typed;
    result_t res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // behavioural copy of the list
  logic [31:0] list_keys [CAPACITY];
  logic [31:0] list_vals [CAPACITY];
  int          list_fill = 0;
  int          even_tally = 0;
  int          odd_tally = 0;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{REQ_POP,    32'h0,        32'h0},        1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_FIND,   32'h0,        32'h0},        1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_DELETE, 32'h0,        32'h0},        1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_APPEND, 32'h7fffffff, 32'h80000000}, 1'b1, '{ST_OK,    32'h0, 32'h0, 7'd1, 7'd1, 7'd0}},
    '{'{REQ_APPEND, 32'h80000000, 32'h7fffffff}, 1'b1, '{ST_OK,    32'h0, 32'h0, 7'd2, 7'd1, 7'd1}},
    '{'{REQ_APPEND, 32'h0,        32'hffffffff}, 1'b1, '{ST_OK,    32'h0, 32'h0, 7'd3, 7'd1, 7'd2}},
    '{'{REQ_APPEND, 32'hffffffff, 32'h0},        1'b1, '{ST_OK,    32'h0, 32'h0, 7'd4, 7'd2, 7'd2}},
    '{'{REQ_APPEND, 32'h0,        32'h2},        1'b1, '{ST_OK,    32'h0, 32'h0, 7'd5, 7'd3, 7'd2}},
    '{'{REQ_FIND,   32'h0,        32'h0},        1'b0, NO_RES},
    '{'{REQ_FIND,   32'h12345,    32'h0},        1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 7'd5, 7'd3, 7'd2}},
    '{'{REQ_DELETE, 32'h12345,    32'h0},        1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 7'd5, 7'd3, 7'd2}},
    '{'{REQ_DELETE, 32'h7fffffff, 32'h0},        1'b0, NO_RES},
    '{'{REQ_DELETE, 32'h0,        32'h0},        1'b0, NO_RES},
    '{'{REQ_FIND,   32'h0,        32'h0},        1'b0, NO_RES},
    '{'{REQ_POP,    32'h0,        32'h0},        1'b0, NO_RES},
    '{'{REQ_DELETE, 32'hffffffff, 32'h0},        1'b0, NO_RES},
    '{'{REQ_DELETE, 32'h80000000, 32'h0},        1'b0, NO_RES},
    '{'{REQ_FIND,   32'h80000000, 32'h0},        1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_APPEND, 32'h5555aaaa, 32'haaaa5555}, 1'b0, NO_RES},
    '{'{REQ_APPEND, 32'haaaa5555, 32'h5555aaaa}, 1'b0, NO_RES},
    '{'{REQ_CLEAR,  32'h0,        32'h0},        1'b1, '{ST_OK,    32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_POP,    32'h0,        32'h0},        1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 7'd0, 7'd0}},
    '{'{REQ_APPEND, 32'h1,        32'h1},        1'b0, NO_RES}
  };

  ordered_keyed_list_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t apply_request(input req_t rq);
    result_t res;
    int      hit;
    res = '0;
    res.status = ST_OK;
    case (rq.op)
      REQ_CLEAR: begin
        list_fill = 0;
        even_tally = 0;
        odd_tally = 0;
      end
      REQ_APPEND: begin
        if (list_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_keys[list_fill] = rq.key;
          list_vals[list_fill] = rq.value;
          list_fill++;
          if (rq.value[0]) odd_tally++;
          else even_tally++;
        end
      end
      REQ_POP: begin
        if (list_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_fill--;
          res.key = list_keys[list_fill];
          res.value = list_vals[list_fill];
          if (res.value[0]) odd_tally--;
          else even_tally--;
        end
      end
      REQ_DELETE, REQ_FIND: begin
        if (list_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < list_fill; i++)
            if (hit < 0 && list_keys[i] == rq.key) hit = i;
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.key = list_keys[hit];
            res.value = list_vals[hit];
            if (rq.op == REQ_DELETE) begin
              // later entries move up to close the gap
              for (int j = hit; j + 1 < list_fill; j++) begin
                list_keys[j] = list_keys[j + 1];
                list_vals[j] = list_vals[j + 1];
              end
              list_fill--;
              if (res.value[0]) odd_tally--;
              else even_tally--;
            end
          end
        end
      end
      default: ;
    endcase
    res.count = list_fill[6:0];
    res.even = even_tally[6:0];
    res.odd = odd_tally[6:0];
    return res;
  endfunction

  // small key pool so that finds, deletes and duplicates hit often
  function automatic logic [31:0] pool_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($urandom_range(15));
    if (r < 85) return $urandom;
    case ($urandom_range(2))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      default: return 32'hffffffff;
    endcase
  endfunction

  // mode 0 fills the list, mode 1 drains it, mode 2 mixes everything
  function automatic req_t random_request(input int mode);
    req_t rq;
    int   r;
    r = $urandom_range(99);
    rq.value = $urandom;
    case (mode)
      0:       rq.op = (r < 88) ? REQ_APPEND : (r < 92) ? REQ_POP :
                       (r < 95) ? REQ_DELETE : REQ_FIND;
      1:       rq.op = (r < 20) ? REQ_APPEND : (r < 55) ? REQ_POP :
                       (r < 80) ? REQ_DELETE : REQ_FIND;
      default: rq.op = (r < 40) ? REQ_APPEND : (r < 55) ? REQ_POP :
                       (r < 75) ? REQ_DELETE : (r < 97) ? REQ_FIND : REQ_CLEAR;
    endcase
    if ((rq.op == REQ_DELETE || rq.op == REQ_FIND) && list_fill > 0 &&
        $urandom_range(99) < 60)
      rq.key = list_keys[$urandom_range(list_fill - 1)];
    else
      rq.key = pool_key();
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch %0s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  task automatic offer(input req_t rq, input bit typed, input result_t typed_res);
    result_t pred;
    in_tdata <= {{(IN_W - 67){1'b0}}, rq.value, rq.key, rq.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = apply_request(rq);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.key = out_tdata[33:2];
      got.value = out_tdata[65:34];
      got.count = out_tdata[72:66];
      got.even = out_tdata[79:73];
      got.odd = out_tdata[86:80];
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", 32'(got.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", 32'(got.status),
                                                       32'(want.status));
        if (got.key != want.key) report_mismatch("out_key", got.key, want.key);
        if (got.value != want.value) report_mismatch("out_value", got.value, want.value);
        if (got.count != want.count) report_mismatch("entry_count", 32'(got.count),
                                                     32'(want.count));
        if (got.even != want.even) report_mismatch("even_count", 32'(got.even),
                                                   32'(want.even));
        if (got.odd != want.odd) report_mismatch("odd_count", 32'(got.odd), 32'(want.odd));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    req_t rq;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      offer(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      phase = seg % 4;
      send_idle_pct <= (phase == 1) ? 71 : (phase == 3) ? 22 : 0;
      recv_stall_pct <= (phase == 2) ? 71 : (phase == 3) ? 22 : 0;
      // sender pause until every outstanding request has answered
      wait_drained();
      if (seg == 4) hold_ticket <= hold_ticket + 1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        idle_gap();
        rq = random_request(seg % 3);
        offer(rq, 1'b0, NO_RES);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
